@@ design/tev_pkg.sv @@
// Package for the trigger event builder: sizes, command and status codes,
// and the request/response structs of the shared compare and add unit.
// Used by every module of the block; depends on nothing else.
package tev_pkg;

    localparam int NUM_LAYERS  = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_W   = $clog2(NUM_LAYERS + 1);
    localparam int MASK_W  = (NUM_LAYERS < 8) ? NUM_LAYERS : 8;

    localparam int CMD_W    = 3;
    localparam int LAYIN_W  = 3;
    localparam int TRIG_W   = 32;
    localparam int HITS_W   = 10;
    localparam int HTOT_W   = 13;
    localparam int MASKO_W  = 8;
    localparam int CFG_W    = 4;
    localparam int ENTRY_W  = HITS_W + TRIG_W;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 88;

    localparam logic [HTOT_W-1:0] HTOT_MAX = '1;
    localparam logic [TRIG_W-1:0] TRIG_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_BUILD = 3'd1,
        CMD_MON   = 3'd2,
        CMD_START = 3'd3,
        CMD_STOP  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_BUILT     = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_MON_COPY  = 3'd3,
        ST_MON_EMPTY = 3'd4,
        ST_PUSHED    = 3'd5,
        ST_OVERFLOW  = 3'd6
    } t_status;

    typedef struct packed {
        logic [TRIG_W-1:0] cand;
        logic [TRIG_W-1:0] base;
        logic [HTOT_W-1:0] acc;
        logic [HITS_W-1:0] add;
    } t_unit_req;

    typedef struct packed {
        logic              lt;
        logic              eq;
        logic [HTOT_W-1:0] sum;
    } t_unit_rsp;

endpackage

@@ design/trigger_event_builder.sv @@
// Trigger event builder top level: command sequencer, queue bookkeeping,
// monitor mailbox and output register. Depends on tev_pkg, tev_qram and
// tev_merge_unit.
//
// The input stream carries one command per request: push a sub-event header
// into a layer queue, try a build, read the monitor mailbox, start or stop.
// Every request yields exactly one result on the output stream, whose tuser
// holds the status code. The user must write the active_layers register through
// i_cfg_we/i_cfg_wdata only while the block is idle, which it does not enforce.
// Push, monitor, start, stop and unknown commands finish in S_EXEC: the result
// is written to the output register, or parked while that is busy, and the
// sequencer returns to idle to take the next request. A build that goes ahead
// reads the head of each active layer from the single read port of the queue
// memory (S_LOAD, then S_CAPT), then passes each captured head through the
// shared compare and add unit in S_MATCH. A build that cannot go ahead also
// finishes in S_EXEC.
// After reset all queues are empty, the block is stopped, counters are zero
// and active_layers is 8; no clearing pass is needed. If the receiver stalls,
// the result waits in the output register, one further request is still
// taken and processed, and its result is held until the register frees.
module trigger_event_builder
    import tev_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: layer_index[2:0], trigger_number[34:3], hit_count[44:35], zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: command[2:0]
    input  logic [CMD_W-1:0]       i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: event_trigger[31:0], event_number[63:32], hit_total[76:64],
    // matched_mask[84:77], zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status[2:0]
    output logic [2:0]             o_m_axis_tuser,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_CAPT,
        S_MATCH,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    logic [CMD_W-1:0]   r_cmd,  n_cmd;
    logic [LAYIN_W-1:0] r_lay,  n_lay;
    logic [TRIG_W-1:0]  r_trig, n_trig;
    logic [HITS_W-1:0]  r_hits, n_hits;

    logic [CFG_W-1:0]   r_active, n_active;
    logic               r_running, n_running;
    logic [TRIG_W-1:0]  r_built, n_built;
    logic               r_mon_pend, n_mon_pend;
    logic [TRIG_W-1:0]  r_mon_trig, n_mon_trig;
    logic [TRIG_W-1:0]  r_mon_num, n_mon_num;
    logic [HTOT_W-1:0]  r_mon_hits, n_mon_hits;

    logic [PTR_W-1:0]   r_head [NUM_LAYERS];
    logic [PTR_W-1:0]   n_head [NUM_LAYERS];
    logic [FILL_W-1:0]  r_fill [NUM_LAYERS];
    logic [FILL_W-1:0]  n_fill [NUM_LAYERS];

    logic [TRIG_W-1:0]  r_cap_trig [NUM_LAYERS];
    logic [TRIG_W-1:0]  n_cap_trig [NUM_LAYERS];
    logic [HITS_W-1:0]  r_cap_hits [NUM_LAYERS];
    logic [HITS_W-1:0]  n_cap_hits [NUM_LAYERS];

    logic [CNT_W-1:0]      r_idx, n_idx;
    logic [TRIG_W-1:0]     r_min, n_min;
    logic [HTOT_W-1:0]     r_acc, n_acc;
    logic [NUM_LAYERS-1:0] r_match, n_match;
    logic                  r_miss, n_miss;

    logic               r_out_valid, n_out_valid;
    logic [2:0]         r_out_st, n_out_st;
    logic [TRIG_W-1:0]  r_out_trig, n_out_trig;
    logic [TRIG_W-1:0]  r_out_num, n_out_num;
    logic [HTOT_W-1:0]  r_out_hits, n_out_hits;
    logic [MASKO_W-1:0] r_out_mask, n_out_mask;

    logic [2:0]         r_res_st, n_res_st;
    logic [TRIG_W-1:0]  r_res_trig, n_res_trig;
    logic [TRIG_W-1:0]  r_res_num, n_res_num;
    logic [HTOT_W-1:0]  r_res_hits, n_res_hits;
    logic [MASKO_W-1:0] r_res_mask, n_res_mask;

    logic               f_fin;
    logic [2:0]         f_st;
    logic [TRIG_W-1:0]  f_trig;
    logic [TRIG_W-1:0]  f_num;
    logic [HTOT_W-1:0]  f_hits;
    logic [MASKO_W-1:0] f_mask;

    logic [CNT_W-1:0]   w_n;
    logic [CNT_W-1:0]   w_idx_inc;
    logic [LAYER_W-1:0] w_sel;
    logic               w_lay_ok;
    logic               w_q_full;
    logic               w_can_build;
    logic               w_out_free;
    logic               w_accept;
    logic [PTR_W:0]     w_wsum;
    logic [PTR_W-1:0]   w_wptr;
    logic [PTR_W-1:0]   w_head_inc;
    logic               w_we;
    logic [ENTRY_W-1:0] w_rdata;
    t_unit_req          w_req;
    t_unit_rsp          w_rsp;

    tev_qram u_qram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_wlayer (w_sel),
        .i_wptr   (w_wptr),
        .i_wdata  ({r_hits, r_trig}),
        .i_rlayer (w_sel),
        .i_rptr   (r_head[w_sel]),
        .o_rdata  (w_rdata)
    );

    tev_merge_unit u_unit (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // An active layer count of zero means one layer; larger than the build
    // means all layers.
    always_comb begin
        if (r_active == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_active) > NUM_LAYERS) begin
            w_n = CNT_W'(NUM_LAYERS);
        end else begin
            w_n = CNT_W'(r_active);
        end
    end

    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_sel     = (r_cmd == CMD_PUSH) ? LAYER_W'(r_lay) : r_idx[LAYER_W-1:0];
    assign w_lay_ok  = 32'(r_lay) < NUM_LAYERS;
    assign w_q_full  = r_fill[w_sel] == FILL_W'(QUEUE_DEPTH);
    assign w_wsum    = (PTR_W + 1)'(r_head[w_sel]) + (PTR_W + 1)'(r_fill[w_sel]);
    assign w_wptr    = (w_wsum >= (PTR_W + 1)'(QUEUE_DEPTH))
                     ? PTR_W'(w_wsum - (PTR_W + 1)'(QUEUE_DEPTH)) : PTR_W'(w_wsum);
    assign w_head_inc = (r_head[w_sel] == PTR_W'(QUEUE_DEPTH - 1))
                      ? '0 : r_head[w_sel] + PTR_W'(1);
    assign w_we = (r_state == S_EXEC) && (r_cmd == CMD_PUSH) && w_lay_ok && !w_q_full;

    always_comb begin
        w_can_build = r_running;
        for (int l = 0; l < NUM_LAYERS; l++) begin
            if ((CNT_W'(l) < w_n) && (r_fill[l] == '0)) begin
                w_can_build = 1'b0;
            end
        end
    end

    // The shared unit compares against the running minimum in both passes:
    // during capture the candidate is the memory word, during matching it
    // is the captured head of the current layer.
    always_comb begin
        w_req.base = r_min;
        w_req.acc  = r_acc;
        if (r_state == S_CAPT) begin
            w_req.cand = w_rdata[TRIG_W-1:0];
            w_req.add  = w_rdata[ENTRY_W-1:TRIG_W];
        end else begin
            w_req.cand = r_cap_trig[w_sel];
            w_req.add  = r_cap_hits[w_sel];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_lay      = r_lay;
        n_trig     = r_trig;
        n_hits     = r_hits;
        n_active   = i_cfg_we ? i_cfg_wdata : r_active;
        n_running  = r_running;
        n_built    = r_built;
        n_mon_pend = r_mon_pend;
        n_mon_trig = r_mon_trig;
        n_mon_num  = r_mon_num;
        n_mon_hits = r_mon_hits;
        n_head     = r_head;
        n_fill     = r_fill;
        n_cap_trig = r_cap_trig;
        n_cap_hits = r_cap_hits;
        n_idx      = r_idx;
        n_min      = r_min;
        n_acc      = r_acc;
        n_match    = r_match;
        n_miss     = r_miss;

        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_st    = r_out_st;
        n_out_trig  = r_out_trig;
        n_out_num   = r_out_num;
        n_out_hits  = r_out_hits;
        n_out_mask  = r_out_mask;
        n_res_st    = r_res_st;
        n_res_trig  = r_res_trig;
        n_res_num   = r_res_num;
        n_res_hits  = r_res_hits;
        n_res_mask  = r_res_mask;

        f_fin  = 1'b0;
        f_st   = ST_NONE;
        f_trig = '0;
        f_num  = '0;
        f_hits = '0;
        f_mask = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_s_axis_tuser;
                    n_lay   = i_s_axis_tdata[LAYIN_W-1:0];
                    n_trig  = i_s_axis_tdata[LAYIN_W +: TRIG_W];
                    n_hits  = i_s_axis_tdata[LAYIN_W + TRIG_W +: HITS_W];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_PUSH: begin
                        f_fin  = 1'b1;
                        f_trig = r_trig;
                        f_hits = HTOT_W'(r_hits);
                        f_mask = w_lay_ok ? (MASKO_W'(1) << r_lay) : '0;
                        if (w_lay_ok && !w_q_full) begin
                            f_st = ST_PUSHED;
                            n_fill[w_sel] = r_fill[w_sel] + FILL_W'(1);
                        end else begin
                            f_st = ST_OVERFLOW;
                        end
                    end
                    CMD_BUILD: begin
                        if (w_can_build) begin
                            n_idx   = '0;
                            n_min   = TRIG_MAX;
                            n_state = S_LOAD;
                        end else begin
                            f_fin = 1'b1;
                        end
                    end
                    CMD_MON: begin
                        f_fin = 1'b1;
                        if (r_mon_pend) begin
                            f_st       = ST_MON_COPY;
                            f_trig     = r_mon_trig;
                            f_num      = r_mon_num;
                            f_hits     = r_mon_hits;
                            n_mon_pend = 1'b0;
                        end else begin
                            f_st = ST_MON_EMPTY;
                        end
                    end
                    CMD_START: begin
                        f_fin      = 1'b1;
                        n_built    = '0;
                        n_mon_pend = 1'b0;
                        n_running  = 1'b1;
                    end
                    CMD_STOP: begin
                        f_fin     = 1'b1;
                        n_running = 1'b0;
                    end
                    default: begin
                        f_fin = 1'b1;
                    end
                endcase
            end
            S_LOAD: begin
                n_state = S_CAPT;
            end
            S_CAPT: begin
                n_cap_trig[w_sel] = w_rdata[TRIG_W-1:0];
                n_cap_hits[w_sel] = w_rdata[ENTRY_W-1:TRIG_W];
                if (w_rsp.lt) begin
                    n_min = w_req.cand;
                end
                if (w_idx_inc == w_n) begin
                    n_idx   = '0;
                    n_acc   = '0;
                    n_match = '0;
                    n_miss  = 1'b0;
                    n_state = S_MATCH;
                end else begin
                    n_idx   = w_idx_inc;
                    n_state = S_LOAD;
                end
            end
            S_MATCH: begin
                if (w_rsp.eq) begin
                    n_acc          = w_rsp.sum;
                    n_match[w_sel] = 1'b1;
                    n_head[w_sel]  = w_head_inc;
                    n_fill[w_sel]  = r_fill[w_sel] - FILL_W'(1);
                end else begin
                    n_miss = 1'b1;
                end
                n_idx = w_idx_inc;
                if (w_idx_inc == w_n) begin
                    f_fin  = 1'b1;
                    f_trig = r_min;
                    f_hits = n_acc;
                    f_mask = MASKO_W'(n_match[MASK_W-1:0]);
                    if (!n_miss) begin
                        f_st    = ST_BUILT;
                        f_num   = r_built;
                        n_built = r_built + TRIG_W'(1);
                        if (!r_mon_pend) begin
                            n_mon_pend = 1'b1;
                            n_mon_trig = r_min;
                            n_mon_num  = r_built;
                            n_mon_hits = n_acc;
                        end
                    end else begin
                        f_st = ST_DROPPED;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_res_st;
                    n_out_trig  = r_res_trig;
                    n_out_num   = r_res_num;
                    n_out_hits  = r_res_hits;
                    n_out_mask  = r_res_mask;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free, otherwise it is parked until the receiver takes the old one.
        if (f_fin) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_st    = f_st;
                n_out_trig  = f_trig;
                n_out_num   = f_num;
                n_out_hits  = f_hits;
                n_out_mask  = f_mask;
                n_state     = S_IDLE;
            end else begin
                n_res_st   = f_st;
                n_res_trig = f_trig;
                n_res_num  = f_num;
                n_res_hits = f_hits;
                n_res_mask = f_mask;
                n_state    = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= CFG_W'(8);
            r_running   <= 1'b0;
            r_built     <= '0;
            r_mon_pend  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int l = 0; l < NUM_LAYERS; l++) begin
                r_head[l] <= '0;
                r_fill[l] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_running   <= n_running;
            r_built     <= n_built;
            r_mon_pend  <= n_mon_pend;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_cmd       <= n_cmd;
            r_lay       <= n_lay;
            r_trig      <= n_trig;
            r_hits      <= n_hits;
            r_mon_trig  <= n_mon_trig;
            r_mon_num   <= n_mon_num;
            r_mon_hits  <= n_mon_hits;
            r_cap_trig  <= n_cap_trig;
            r_cap_hits  <= n_cap_hits;
            r_min       <= n_min;
            r_acc       <= n_acc;
            r_match     <= n_match;
            r_miss      <= n_miss;
            r_out_st    <= n_out_st;
            r_out_trig  <= n_out_trig;
            r_out_num   <= n_out_num;
            r_out_hits  <= n_out_hits;
            r_out_mask  <= n_out_mask;
            r_res_st    <= n_res_st;
            r_res_trig  <= n_res_trig;
            r_res_num   <= n_res_num;
            r_res_hits  <= n_res_hits;
            r_res_mask  <= n_res_mask;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tdata  = {3'b000, r_out_mask, r_out_hits, r_out_num, r_out_trig};

endmodule

@@ design/tev_qram.sv @@
// Sub-event queue storage: one entry array per layer, one write and one
// registered read port. Depends on tev_pkg for the sizes.
module tev_qram
    import tev_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [LAYER_W-1:0] i_wlayer,
    input  logic [PTR_W-1:0]   i_wptr,
    input  logic [ENTRY_W-1:0] i_wdata,
    input  logic [LAYER_W-1:0] i_rlayer,
    input  logic [PTR_W-1:0]   i_rptr,
    output logic [ENTRY_W-1:0] o_rdata
);

    logic [ENTRY_W-1:0] r_mem [NUM_LAYERS][QUEUE_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wlayer][i_wptr] <= i_wdata;
        end
        r_rdata <= r_mem[i_rlayer][i_rptr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/tev_merge_unit.sv @@
// Shared compare and saturating add unit, used for the minimum search and
// for the match and hit summing passes. Depends on tev_pkg.
module tev_merge_unit
    import tev_pkg::*;
(
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic [HTOT_W:0] w_sum;

    assign w_sum = {1'b0, i_req.acc} + (HTOT_W + 1)'(i_req.add);

    always_comb begin
        o_rsp.lt  = i_req.cand < i_req.base;
        o_rsp.eq  = i_req.cand == i_req.base;
        o_rsp.sum = w_sum[HTOT_W] ? HTOT_MAX : w_sum[HTOT_W-1:0];
    end

endmodule

@@ design/tev_checker.sv @@
// Port-level checks for the trigger event builder, attached by a bind.
// Depends on tev_pkg for the status codes and bus widths.
module tev_checker
    import tev_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [2:0]             o_m_axis_tuser
);

    // A stalled result must not change under the receiver.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("output result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    // The sequencer takes no new request while the previous one is in work.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while the previous one is in work");

    // Layer 0 always takes part, so a built event always reports it.
    a_built_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_BUILT)) |-> o_m_axis_tdata[77])
        else $error("built event without layer 0 in its mask");

    a_push_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && ((o_m_axis_tuser == ST_PUSHED) ||
                             (o_m_axis_tuser == ST_OVERFLOW)))
            |-> (o_m_axis_tdata[76:74] == 3'b000))
        else $error("push echo carries a hit count beyond ten bits");

endmodule

bind trigger_event_builder tev_checker u_tev_checker (.*);
